### rtl/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

  // Fixed-point format of c and z
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned FracBits = 28;

  // Result and register widths
  localparam int unsigned MaxIterW     = 16;
  localparam int unsigned IterOutW     = 16;
  localparam int unsigned CountW       = 32;
  localparam logic [MaxIterW-1:0] MaxIterReset = 16'd1000;

  // Default width of the update counter
  localparam int unsigned IterBitsDef = 16;

  // Depth of the request queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Escape threshold: 4.0 with 2*FracBits fraction bits
  localparam int unsigned ThrShift  = 2 * FracBits + 2;
  localparam bit          EscEnable = (ThrShift < ProdW);
  localparam logic [ProdW-1:0] EscThr =
    EscEnable ? (ProdW'(1) << (ThrShift % ProdW)) : '0;

  typedef struct packed {
    logic signed [DataW-1:0] c_real;
    logic signed [DataW-1:0] c_imag;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } core_state_e;

  // Clamp a wide signed value to the signed DataW range
  function automatic logic signed [DataW-1:0] sat_data(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'({1'b0, {(DataW-1){1'b1}}});
    lo = -hi - ProdW'(1);
    if (v > hi) begin
      sat_data = hi[DataW-1:0];
    end else if (v < lo) begin
      sat_data = lo[DataW-1:0];
    end else begin
      sat_data = v[DataW-1:0];
    end
  endfunction

endpackage

### rtl/mbe_if.sv
`timescale 1ns / 1ps

// Point request channel
interface mbe_point_if;
  import mbe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] c_real;
  logic signed [DataW-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// Result channel
interface mbe_result_if;
  import mbe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 escaped;
  logic [IterOutW-1:0]  iterations;
  logic [CountW-1:0]    outside_count;

  modport source (output valid, output escaped, output iterations, output outside_count,
                  input ready);
  modport sink   (input valid, input escaped, input iterations, input outside_count,
                  output ready);
endinterface

// Configuration write channel (max_iter)
interface mbe_cfg_if;
  import mbe_pkg::*;
  logic                valid;
  logic                ready;
  logic [MaxIterW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mbe_front.sv
`timescale 1ns / 1ps

module mbe_front import mbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mbe_point_if.sink   in_i,
  mbe_point_if.source out_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  point_t             mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               push, pop;

  assign in_i.ready  = (count_q != CntW'(QueueDepth));
  assign out_o.valid = (count_q != '0);
  assign push        = in_i.valid & in_i.ready;
  assign pop         = out_o.valid & out_o.ready;

  assign out_o.c_real = mem_q[rd_ptr_q].c_real;
  assign out_o.c_imag = mem_q[rd_ptr_q].c_imag;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{c_real: in_i.c_real, c_imag: in_i.c_imag};
    end
  end

endmodule

### rtl/mbe_core.sv
`timescale 1ns / 1ps

module mbe_core import mbe_pkg::*; #(
  parameter int unsigned IterBits = IterBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MaxIterW-1:0] max_iter_i,
  mbe_point_if.sink           pt_i,
  mbe_result_if.source        res_o
);

  core_state_e state_q, state_d;

  logic signed [DataW-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [ProdW-1:0] rr_q, ii_q, ri_q;
  logic [IterBits-1:0]     n_q;
  logic                    tested_q;
  logic                    esc_q;
  logic [IterOutW-1:0]     idx_q;
  logic [CountW-1:0]       total_q;

  logic                    res_valid_q;
  logic                    res_esc_q;
  logic [IterOutW-1:0]     res_iter_q;
  logic [CountW-1:0]       res_count_q;

  logic [IterBits+MaxIterW-1:0] limit_ext;
  logic [IterBits-1:0]          limit;
  logic [IterBits+IterOutW-1:0] limit_out_ext;
  logic [IterBits+IterOutW-1:0] esc_idx_ext;

  logic [ProdW-1:0]        mag;
  logic signed [ProdW-1:0] diff, re_sum, im_sum;
  logic                    esc_hit, at_limit;
  logic [CountW-1:0]       total_next;

  logic take_item, do_mul, do_step, fin_esc, fin_in, emit;

  // iteration limit and index at the counter width
  assign limit_ext     = {{IterBits{1'b0}}, max_iter_i};
  assign limit         = limit_ext[IterBits-1:0];
  assign limit_out_ext = {{IterOutW{1'b0}}, limit};
  assign esc_idx_ext   = {{IterOutW{1'b0}}, n_q - IterBits'(1)};

  // escape test on the squares already taken for the next update
  assign mag      = $unsigned(rr_q) + $unsigned(ii_q);
  assign esc_hit  = EscEnable && tested_q && (mag > EscThr);
  assign at_limit = (n_q == limit);

  // z*z + c, scaled back with floor shifts
  assign diff   = rr_q - ii_q;
  assign re_sum = (diff >>> FracBits) + ProdW'(cr_q);
  assign im_sum = (ri_q >>> (FracBits - 1)) + ProdW'(ci_q);

  // saturating escape count
  assign total_next = (esc_q && (total_q != '1)) ? total_q + CountW'(1) : total_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pt_i.valid) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (esc_hit || at_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take_item = 1'b0;
    do_mul    = 1'b0;
    do_step   = 1'b0;
    fin_esc   = 1'b0;
    fin_in    = 1'b0;
    emit      = 1'b0;
    case (state_q)
      ST_IDLE: take_item = pt_i.valid;
      ST_MUL:  do_mul = 1'b1;
      ST_UPD: begin
        fin_esc = esc_hit;
        fin_in  = !esc_hit && at_limit;
        do_step = !esc_hit && !at_limit;
      end
      ST_DONE: emit = !res_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign pt_i.ready = (state_q == ST_IDLE);

  assign res_o.valid         = res_valid_q;
  assign res_o.escaped       = res_esc_q;
  assign res_o.iterations    = res_iter_q;
  assign res_o.outside_count = res_count_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        res_valid_q <= 1'b1;
        total_q     <= total_next;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take_item) begin
      cr_q     <= pt_i.c_real;
      ci_q     <= pt_i.c_imag;
      zr_q     <= pt_i.c_real;
      zi_q     <= pt_i.c_imag;
      n_q      <= '0;
      tested_q <= 1'b0;
    end
    if (do_mul) begin
      rr_q <= ProdW'(zr_q) * ProdW'(zr_q);
      ii_q <= ProdW'(zi_q) * ProdW'(zi_q);
      ri_q <= ProdW'(zr_q) * ProdW'(zi_q);
    end
    if (do_step) begin
      zr_q     <= sat_data(re_sum);
      zi_q     <= sat_data(im_sum);
      n_q      <= n_q + IterBits'(1);
      tested_q <= 1'b1;
    end
    if (fin_esc) begin
      esc_q <= 1'b1;
      idx_q <= esc_idx_ext[IterOutW-1:0];
    end
    if (fin_in) begin
      esc_q <= 1'b0;
      idx_q <= limit_out_ext[IterOutW-1:0];
    end
    if (emit) begin
      res_esc_q   <= esc_q;
      res_iter_q  <= idx_q;
      res_count_q <= total_next;
    end
  end

endmodule

### rtl/mandelbrot_escape_test_top.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time test. Each request is a point c (signed fixed point,
// 28 fraction bits); the block iterates z = z*z + c from z = c up to max_iter
// times and returns one result: escaped flag, index of the escaping update (or
// max_iter), and a saturating count of escaped points since reset. A point
// that runs k updates holds the engine while it takes the point, runs k + 1
// rounds of a multiply state and an update state (the last round only tests
// |z|^2 or hits the limit) and hands the result to the output register. The
// multiply state uses the shared multiplier set (three 32x32 products, which
// also serve the |z|^2 test); the update state does add, shift and clamp. A
// two-entry request queue and a result register let both sides stall
// independently of the iteration engine. max_iter resets to 1000.
module mandelbrot_escape_test_top import mbe_pkg::*; #(
  parameter int unsigned ITER_BITS = IterBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbe_cfg_if.sink       cfg_i,
  mbe_point_if.sink     point_i,
  mbe_result_if.source  result_o
);

  logic [MaxIterW-1:0] max_iter_q;

  mbe_point_if queue_if ();

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterReset;
    end else if (cfg_i.valid) begin
      max_iter_q <= cfg_i.data;
    end
  end

  // front: request queue
  mbe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (point_i),
    .out_o  (queue_if.source)
  );

  // back: iteration engine
  mbe_core #(
    .IterBits (ITER_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_iter_i (max_iter_q),
    .pt_i       (queue_if.sink),
    .res_o      (result_o)
  );

  // an escape happens strictly before the limit
  a_esc_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.escaped |-> (32'(result_o.iterations) < 32'(max_iter_q)))
    else $error("escape index not below iteration limit");

  // a non-escaping point never reports more than the limit
  a_inside_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.escaped |-> (32'(result_o.iterations) <= 32'(max_iter_q)))
    else $error("inside point reports index above limit");

  // an escaped result is always counted
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.escaped |-> (result_o.outside_count != '0))
    else $error("escaped point missing from outside count");

endmodule
